// ===== sv/circular_doubly_linked_list_engine_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the circular linked list engine
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CDLL_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) prop) else $error("assertion failed");
`define CDLL_ASSERT_NEVER(lbl, cond) `CDLL_ASSERT(lbl, !(cond))
`else
`define CDLL_ASSERT(lbl, prop)
`define CDLL_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== sv/cdll_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular linked list engine package
// Request and status codes, sequencer states and transfer types.
// ----------------------------------------------------------------------------
package cdll_pkg;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_END   = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_READ      = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_FREE,
    S_LINK1,
    S_LINK2,
    S_DREAD,
    S_DFREE,
    S_RDOUT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [7:0]         position;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic               is_last;
  } out_t;

  typedef struct packed {
    logic nxt;
    logic val;
  } mem_we_t;

endpackage

// ===== sv/cdll_node_mem.sv =====
// ----------------------------------------------------------------------------
// Node memory
// Value and next-link arrays with one shared registered read port. Unwritten
// link entries read as the reset free chain through per-entry valid bits.
// ----------------------------------------------------------------------------
module cdll_node_mem #(
  parameter int CAPACITY = 32,
  parameter int IW       = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cdll_pkg::mem_we_t  we_i,
  input  logic [IW-1:0]      raddr_i,
  input  logic [IW-1:0]      nxt_waddr_i,
  input  logic [IW-1:0]      nxt_wdata_i,
  input  logic [IW-1:0]      val_waddr_i,
  input  logic signed [31:0] val_wdata_i,
  output logic [IW-1:0]      nxt_rdata_o,
  output logic signed [31:0] val_rdata_o
);

  logic [IW-1:0]      nxt_mem [CAPACITY];
  logic signed [31:0] val_mem [CAPACITY];
  logic [CAPACITY-1:0] vld_q;
  logic               vld_rd_q;
  logic [IW-1:0]      nxt_raw_q;
  logic [IW-1:0]      dflt_q;
  logic signed [31:0] val_rd_q;
  logic [IW-1:0]      chain;

  assign chain = (raddr_i == IW'(CAPACITY - 1)) ? '0 : raddr_i + 1'b1;

  always_ff @(posedge clk_i) begin
    if (we_i.nxt) begin
      nxt_mem[nxt_waddr_i] <= nxt_wdata_i;
    end
    if (we_i.val) begin
      val_mem[val_waddr_i] <= val_wdata_i;
    end
    nxt_raw_q <= nxt_mem[raddr_i];
    val_rd_q  <= val_mem[raddr_i];
    dflt_q    <= chain;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (we_i.nxt) begin
        vld_q[nxt_waddr_i] <= 1'b1;
      end
      vld_rd_q <= vld_q[raddr_i];
    end
  end

  assign nxt_rdata_o = vld_rd_q ? nxt_raw_q : dflt_q;
  assign val_rdata_o = val_rd_q;

endmodule

// ===== sv/circular_doubly_linked_list_engine_top.sv =====
// Refused requests go straight to S_RESP; inserts pass S_FREE, S_LINK1 and S_LINK2,
// deletes S_DREAD and S_DFREE, readout S_RDOUT. Walks take one link a cycle and run
// first for an insert at 1<p<=n, a delete at p>1 and a delete end of n>1.
// One request at a time: the next is taken the cycle after its last result is registered;
// readout gives one element per cycle while the output is not stalled.
// Reset clears control state at once; link memory reads as the initial free chain.
// ----------------------------------------------------------------------------
// Circular linked list engine, top level
// Sequencer over the node memory for insert, delete and readout requests.
// ----------------------------------------------------------------------------
`include "circular_doubly_linked_list_engine_top_assert.svh"

module circular_doubly_linked_list_engine_top #(
  parameter int CAPACITY = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cdll_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cdll_pkg::out_t out_data_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW + 1 > 8) ? CW + 1 : 8;

  cdll_pkg::state_e state_q, state_d;

  logic [IW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d, cur_q, cur_d;
  logic [CW-1:0] cnt_q, cnt_d, steps_q, steps_d;
  logic          front_q, front_d, end_q, end_d, del_q, del_d;
  logic [1:0]    status_q, status_d;
  logic          out_valid_q;
  cdll_pkg::out_t out_q, out_d;

  logic [IW-1:0]      a_q, a_d, b_q, b_d, n_q, n_d;
  logic signed [31:0] ins_q, ins_d, dval_q, dval_d;

  cdll_pkg::mem_we_t  we;
  logic [IW-1:0]      rd_addr, nxt_waddr, nxt_wdata, val_waddr, nxt_rd;
  logic signed [31:0] val_rd;

  logic            out_free, emit, full, empty, last;
  logic [PW-1:0]   pos_x, cnt_x;
  logic            ins_bad, del_bad, pos_one, pos_end;

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (cnt_q == CW'(CAPACITY));
  assign empty    = (cnt_q == '0);
  assign pos_x    = PW'(in_data_i.position);
  assign cnt_x    = PW'(cnt_q);
  assign pos_one  = (pos_x == PW'(1));
  assign pos_end  = (pos_x == cnt_x + PW'(1));
  assign ins_bad  = !pos_one && ((pos_x == '0) || (pos_x > cnt_x + PW'(1)));
  assign del_bad  = (pos_x == '0) || (pos_x > cnt_x);
  assign last     = (CW'(steps_q + 1'b1) == cnt_q);

  cdll_node_mem #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .we_i        (we),
    .raddr_i     (rd_addr),
    .nxt_waddr_i (nxt_waddr),
    .nxt_wdata_i (nxt_wdata),
    .val_waddr_i (val_waddr),
    .val_wdata_i (ins_q),
    .nxt_rdata_o (nxt_rd),
    .val_rdata_o (val_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdll_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.req_type)
            cdll_pkg::REQ_INS_FRONT, cdll_pkg::REQ_INS_END:
              state_d = full ? cdll_pkg::S_RESP : cdll_pkg::S_FREE;
            cdll_pkg::REQ_INS_POS: begin
              if (ins_bad || full) state_d = cdll_pkg::S_RESP;
              else if (pos_one || pos_end) state_d = cdll_pkg::S_FREE;
              else state_d = cdll_pkg::S_WALK;
            end
            cdll_pkg::REQ_DEL_FRONT:
              state_d = empty ? cdll_pkg::S_RESP : cdll_pkg::S_DREAD;
            cdll_pkg::REQ_DEL_END: begin
              if (empty) state_d = cdll_pkg::S_RESP;
              else if (cnt_q == CW'(1)) state_d = cdll_pkg::S_DREAD;
              else state_d = cdll_pkg::S_WALK;
            end
            cdll_pkg::REQ_DEL_POS: begin
              if (empty || del_bad) state_d = cdll_pkg::S_RESP;
              else if (pos_one) state_d = cdll_pkg::S_DREAD;
              else state_d = cdll_pkg::S_WALK;
            end
            cdll_pkg::REQ_READ:
              state_d = empty ? cdll_pkg::S_RESP : cdll_pkg::S_RDOUT;
            default: state_d = cdll_pkg::S_RESP;
          endcase
        end
      end
      cdll_pkg::S_WALK: begin
        if (steps_q == '0) state_d = del_q ? cdll_pkg::S_DREAD : cdll_pkg::S_FREE;
      end
      cdll_pkg::S_FREE:  state_d = cdll_pkg::S_LINK1;
      cdll_pkg::S_LINK1: state_d = cdll_pkg::S_LINK2;
      cdll_pkg::S_LINK2: if (out_free) state_d = cdll_pkg::S_IDLE;
      cdll_pkg::S_DREAD: state_d = cdll_pkg::S_DFREE;
      cdll_pkg::S_DFREE: if (out_free) state_d = cdll_pkg::S_IDLE;
      cdll_pkg::S_RDOUT: if (out_free && last) state_d = cdll_pkg::S_IDLE;
      cdll_pkg::S_RESP:  if (out_free) state_d = cdll_pkg::S_IDLE;
      default:           state_d = cdll_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    free_d    = free_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    steps_d   = steps_q;
    front_d   = front_q;
    end_d     = end_q;
    del_d     = del_q;
    status_d  = status_q;
    a_d       = a_q;
    b_d       = b_q;
    n_d       = n_q;
    ins_d     = ins_q;
    dval_d    = dval_q;
    we        = '0;
    rd_addr   = cur_q;
    nxt_waddr = a_q;
    nxt_wdata = n_q;
    val_waddr = free_q;
    emit      = 1'b0;
    out_d     = out_q;
    unique case (state_q)
      cdll_pkg::S_IDLE: begin
        rd_addr = head_q;
        if (in_valid_i) begin
          cur_d   = head_q;
          ins_d   = in_data_i.value;
          a_d     = tail_q;
          b_d     = head_q;
          steps_d = CW'(pos_x - PW'(2));
          del_d   = 1'b0;
          front_d = 1'b0;
          end_d   = 1'b0;
          status_d = cdll_pkg::ST_INVALID;
          unique case (in_data_i.req_type)
            cdll_pkg::REQ_INS_FRONT: begin
              front_d  = 1'b1;
              status_d = cdll_pkg::ST_FULL;
            end
            cdll_pkg::REQ_INS_END: begin
              end_d    = 1'b1;
              status_d = cdll_pkg::ST_FULL;
            end
            cdll_pkg::REQ_INS_POS: begin
              front_d  = pos_one;
              end_d    = !pos_one && pos_end;
              status_d = ins_bad ? cdll_pkg::ST_INVALID : cdll_pkg::ST_FULL;
            end
            cdll_pkg::REQ_DEL_FRONT: begin
              del_d    = 1'b1;
              status_d = cdll_pkg::ST_EMPTY;
            end
            cdll_pkg::REQ_DEL_END: begin
              del_d    = 1'b1;
              steps_d  = cnt_q - CW'(2);
              status_d = cdll_pkg::ST_EMPTY;
            end
            cdll_pkg::REQ_DEL_POS: begin
              del_d    = 1'b1;
              status_d = empty ? cdll_pkg::ST_EMPTY : cdll_pkg::ST_INVALID;
            end
            cdll_pkg::REQ_READ: begin
              steps_d  = '0;
              status_d = cdll_pkg::ST_EMPTY;
            end
            default: status_d = cdll_pkg::ST_INVALID;
          endcase
        end
      end
      cdll_pkg::S_WALK: begin
        if (steps_q != '0) begin
          cur_d   = nxt_rd;
          rd_addr = nxt_rd;
          steps_d = steps_q - 1'b1;
        end else begin
          a_d = cur_q;
          b_d = nxt_rd;
          if (del_q) rd_addr = nxt_rd;
        end
      end
      cdll_pkg::S_FREE: begin
        rd_addr = free_q;
      end
      cdll_pkg::S_LINK1: begin
        n_d       = free_q;
        free_d    = nxt_rd;
        we.val    = 1'b1;
        val_waddr = free_q;
        we.nxt    = 1'b1;
        nxt_waddr = free_q;
        nxt_wdata = empty ? free_q : b_q;
        if (empty) begin
          head_d = free_q;
          tail_d = free_q;
        end else if (front_q) begin
          head_d = free_q;
        end else if (end_q) begin
          tail_d = free_q;
        end
      end
      cdll_pkg::S_LINK2: begin
        if (out_free) begin
          we.nxt    = !empty;
          nxt_waddr = a_q;
          nxt_wdata = n_q;
          cnt_d     = cnt_q + 1'b1;
          emit      = 1'b1;
          out_d     = '{status: cdll_pkg::ST_OK, data_out: '0, is_last: 1'b1};
        end
      end
      cdll_pkg::S_DREAD: begin
        dval_d = val_rd;
        if (cnt_q == CW'(1)) begin
          head_d = '0;
        end else begin
          we.nxt    = 1'b1;
          nxt_waddr = a_q;
          nxt_wdata = nxt_rd;
          if (b_q == head_q) head_d = nxt_rd;
          if (b_q == tail_q) tail_d = a_q;
        end
      end
      cdll_pkg::S_DFREE: begin
        if (out_free) begin
          we.nxt    = 1'b1;
          nxt_waddr = b_q;
          nxt_wdata = free_q;
          free_d    = b_q;
          cnt_d     = cnt_q - 1'b1;
          emit      = 1'b1;
          out_d     = '{status: cdll_pkg::ST_OK, data_out: dval_q, is_last: 1'b1};
        end
      end
      cdll_pkg::S_RDOUT: begin
        if (out_free) begin
          emit  = 1'b1;
          out_d = '{status: cdll_pkg::ST_OK, data_out: val_rd, is_last: last};
          if (!last) begin
            cur_d   = nxt_rd;
            rd_addr = nxt_rd;
            steps_d = steps_q + 1'b1;
          end
        end
      end
      cdll_pkg::S_RESP: begin
        if (out_free) begin
          emit  = 1'b1;
          out_d = '{status: status_q, data_out: '0, is_last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdll_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_q      <= '0;
      cur_q       <= '0;
      cnt_q       <= '0;
      steps_q     <= '0;
      front_q     <= 1'b0;
      end_q       <= 1'b0;
      del_q       <= 1'b0;
      status_q    <= cdll_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      steps_q     <= steps_d;
      front_q     <= front_d;
      end_q       <= end_d;
      del_q       <= del_d;
      status_q    <= status_d;
      out_valid_q <= emit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    n_q    <= n_d;
    ins_q  <= ins_d;
    dval_q <= dval_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != cdll_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CDLL_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY))
  `CDLL_ASSERT(a_cnt_step, (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + 1'b1) || (cnt_q + 1'b1 == $past(cnt_q))))
  `CDLL_ASSERT_NEVER(a_no_overwrite, emit && out_valid_q && out_stall_i)

endmodule
